### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// each macro expects clk in scope, and WMDC_ASSERT also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WMDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WMDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WMDC_ASSERT(lbl, prop, msg)
`define WMDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/wmdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdc_pkg
// shared constants and controller/datapath types for the weighted median block
// ----------------------------------------------------------------------------
package wmdc_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int VALUE_BITS_DEF  = 20;
  localparam int WEIGHT_BITS_DEF = 20;
  localparam int COST_W          = 50;

  typedef enum logic [1:0] {
    SCAN_TOTAL,
    SCAN_BELOW,
    SCAN_COST
  } scan_mode_t;

  typedef struct packed {
    logic       load;
    logic       clear_cnt;
    logic       start_scan;
    scan_mode_t mode;
    logic       set_target;
    logic       lat_cand;
    logic       judge;
    logic       next_j;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic skip;
    logic j_done;
  } sts_t;

endpackage

### rtl/wmdc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdc_in_if
// input channel: one (value, weight) pair per transaction
// ----------------------------------------------------------------------------
interface wmdc_in_if #(
  parameter int VALUE_BITS  = wmdc_pkg::VALUE_BITS_DEF,
  parameter int WEIGHT_BITS = wmdc_pkg::WEIGHT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  item_value;
  logic [WEIGHT_BITS-1:0] item_weight;
  logic                   is_last;

  modport source (output valid, item_value, item_weight, is_last, input ready);
  modport sink   (input valid, item_value, item_weight, is_last, output ready);
endinterface

// ----------------------------------------------------------------------------
// wmdc_out_if
// result channel: median and weighted deviation cost
// ----------------------------------------------------------------------------
interface wmdc_out_if #(
  parameter int VALUE_BITS = wmdc_pkg::VALUE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [VALUE_BITS-1:0]       median_value;
  logic [wmdc_pkg::COST_W-1:0] total_cost;

  modport source (output valid, median_value, total_cost, input ready);
  modport sink   (input valid, median_value, total_cost, output ready);
endinterface

### rtl/wmdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wmdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/wmdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdc_ctrl
// sequencer for load, total, median search, cost and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wmdc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output wmdc_pkg::cmd_t cmd,
  input  wmdc_pkg::sts_t sts
);
  typedef enum logic [2:0] {
    S_LOAD,
    S_TOT_GO,
    S_TOT_WAIT,
    S_PICK_RD,
    S_PICK_LAT,
    S_PICK_SCAN,
    S_COST_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mode  = wmdc_pkg::SCAN_TOTAL;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_TOT_GO;
        end
      end
      S_TOT_GO: begin
        cmd.start_scan = 1'b1;
        cmd.mode       = wmdc_pkg::SCAN_TOTAL;
        state_nxt      = S_TOT_WAIT;
      end
      S_TOT_WAIT: begin
        if (!sts.scan_busy) begin
          cmd.set_target = 1'b1;
          state_nxt      = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        if (sts.j_done) begin
          cmd.start_scan = 1'b1;
          cmd.mode       = wmdc_pkg::SCAN_COST;
          state_nxt      = S_COST_WAIT;
        end else begin
          state_nxt = S_PICK_LAT;
        end
      end
      S_PICK_LAT: begin
        // candidate not below current median cannot improve it
        if (sts.skip) begin
          cmd.next_j = 1'b1;
          state_nxt  = S_PICK_RD;
        end else begin
          cmd.lat_cand   = 1'b1;
          cmd.start_scan = 1'b1;
          cmd.mode       = wmdc_pkg::SCAN_BELOW;
          state_nxt      = S_PICK_SCAN;
        end
      end
      S_PICK_SCAN: begin
        if (!sts.scan_busy) begin
          cmd.judge = 1'b1;
          state_nxt = S_PICK_RD;
        end
      end
      S_COST_WAIT: begin
        if (!sts.scan_busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          cmd.clear_cnt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WMDC_ASSERT(a_no_load_while_scan, sts.scan_busy |-> !in_ready, "input taken during scan")
  `WMDC_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE),
               "result raised outside done")
  `WMDC_ASSERT(a_judge_returns, (state_r == S_PICK_SCAN && !sts.scan_busy) |=>
               (state_r == S_PICK_RD), "median search step lost")
endmodule

### rtl/wmdc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdc_dp
// element store, scan engine, accumulators and result registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wmdc_dp #(
  parameter int MAX_ITEMS   = wmdc_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS  = wmdc_pkg::VALUE_BITS_DEF,
  parameter int WEIGHT_BITS = wmdc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wmdc_pkg::cmd_t              cmd,
  output wmdc_pkg::sts_t              sts,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic [WEIGHT_BITS-1:0]      in_weight,
  output logic [VALUE_BITS-1:0]       out_median,
  output logic [wmdc_pkg::COST_W-1:0] out_cost
);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int TW = WEIGHT_BITS + CW;
  localparam int DW = VALUE_BITS + WEIGHT_BITS;
  localparam int PW = VALUE_BITS + WEIGHT_BITS;

  logic [CW-1:0]              cnt_r, k_r, j_r;
  logic                       act_r, rv_r, pv_r, found_r;
  wmdc_pkg::scan_mode_t       mode_r;
  logic [TW-1:0]              acc_r, target_r;
  logic [wmdc_pkg::COST_W-1:0] cost_r;
  logic [PW-1:0]              prod_r;
  logic [VALUE_BITS-1:0]      cand_r, median_r;
  logic [DW-1:0]              rdata;
  logic [VALUE_BITS-1:0]      rd_v, gap;
  logic [WEIGHT_BITS-1:0]     rd_w;
  logic                       we;
  logic [AW-1:0]              raddr;

  assign we    = cmd.load && (cnt_r < CW'(MAX_ITEMS));
  assign raddr = act_r ? k_r[AW-1:0] : j_r[AW-1:0];
  assign rd_v  = rdata[DW-1:WEIGHT_BITS];
  assign rd_w  = rdata[WEIGHT_BITS-1:0];
  assign gap   = (rd_v >= median_r) ? (rd_v - median_r) : (median_r - rd_v);

  wmdc_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_value, in_weight}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.scan_busy = act_r | rv_r | pv_r;
  assign sts.skip      = found_r && (rd_v >= median_r);
  assign sts.j_done    = (j_r == cnt_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      act_r   <= 1'b0;
      rv_r    <= 1'b0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.clear_cnt) cnt_r <= '0;
      else if (we) cnt_r <= cnt_r + CW'(1);
      if (cmd.start_scan) act_r <= (cnt_r != '0);
      else if (act_r && (k_r == cnt_r - CW'(1))) act_r <= 1'b0;
      rv_r <= act_r;
      pv_r <= rv_r && (mode_r == wmdc_pkg::SCAN_COST);
      if (cmd.set_target) found_r <= 1'b0;
      else if (cmd.judge && (acc_r >= target_r)) found_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      k_r    <= '0;
      mode_r <= cmd.mode;
      acc_r  <= '0;
      if (cmd.mode == wmdc_pkg::SCAN_COST) cost_r <= '0;
    end else begin
      if (act_r) k_r <= k_r + CW'(1);
      if (rv_r) begin
        unique case (mode_r)
          wmdc_pkg::SCAN_TOTAL: acc_r <= acc_r + TW'(rd_w);
          wmdc_pkg::SCAN_BELOW: if (rd_v <= cand_r) acc_r <= acc_r + TW'(rd_w);
          wmdc_pkg::SCAN_COST:  prod_r <= PW'(gap) * PW'(rd_w);
          default: ;
        endcase
      end
      if (pv_r) cost_r <= cost_r + wmdc_pkg::COST_W'(prod_r);
    end
    if (cmd.set_target) begin
      target_r <= (acc_r >> 1) + TW'(acc_r[0]);
      median_r <= '0;
      j_r      <= '0;
    end else if (cmd.judge) begin
      if (acc_r >= target_r) median_r <= cand_r;
      j_r <= j_r + CW'(1);
    end else if (cmd.next_j) begin
      j_r <= j_r + CW'(1);
    end
    if (cmd.lat_cand) cand_r <= rd_v;
    if (cmd.publish) begin
      out_median <= median_r;
      out_cost   <= cost_r;
    end
  end

  `WMDC_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_ITEMS), "element count above capacity")
  `WMDC_ASSERT(a_scan_in_range, act_r |-> (k_r < cnt_r), "scan index past count")
  `WMDC_ASSERT(a_read_follows_scan, rv_r |-> $past(act_r), "read data without scan")
endmodule

### rtl/weighted_median_deviation_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_median_deviation_cost
// weighted median of a loaded set and its weighted absolute deviation cost
// ----------------------------------------------------------------------------
// channel  dir  fields                               transaction
// in_ch    in   item_value, item_weight, is_last     valid && ready
// out_ch   out  median_value, total_cost             valid && ready
//
// loading takes a pair whenever in_ch is valid; up to MAX_ITEMS pairs are kept
// in a ram with one read port and later pairs are dropped; after the last pair
// come a total pass, a median search (a full ram pass per candidate that is not
// skipped) and a cost pass; no pair is taken until the result is registered,
// which may then wait for out_ch while the next set loads
// rst_n is synchronous; nothing in the ram needs clearing
// ----------------------------------------------------------------------------
module weighted_median_deviation_cost #(
  parameter int MAX_ITEMS   = wmdc_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS  = wmdc_pkg::VALUE_BITS_DEF,
  parameter int WEIGHT_BITS = wmdc_pkg::WEIGHT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wmdc_in_if.sink   in_ch,
  wmdc_out_if.source out_ch
);
  wmdc_pkg::cmd_t cmd;
  wmdc_pkg::sts_t sts;

  wmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.is_last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wmdc_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_BITS  (VALUE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_ch.item_value),
    .in_weight  (in_ch.item_weight),
    .out_median (out_ch.median_value),
    .out_cost   (out_ch.total_cost)
  );
endmodule

### sim/tb_weighted_median_deviation_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_median_deviation_cost
// self-checking bench: loads (value, weight) sets, predicts the weighted
// median and its deviation cost, and compares every result transaction
// ----------------------------------------------------------------------------
module tb_weighted_median_deviation_cost;

  localparam int VB = wmdc_pkg::VALUE_BITS_DEF;
  localparam int WB = wmdc_pkg::WEIGHT_BITS_DEF;
  localparam int CAP = wmdc_pkg::MAX_ITEMS_DEF;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int VMAX = (1 << VB) - 1;
  localparam int WMAX = (1 << WB) - 1;

  class median_cost_board;
    logic [VB-1:0] set_vals[$];
    logic [WB-1:0] set_wts[$];
    logic [VB-1:0] exp_median[$];
    logic [wmdc_pkg::COST_W-1:0] exp_cost[$];
    int errors = 0;

    function void note_pair(logic [VB-1:0] v, logic [WB-1:0] w, logic last);
      longint unsigned total, target, acc, cost, d;
      logic [VB-1:0] med;
      bit found;
      if (set_vals.size() < CAP) begin
        set_vals = {set_vals, v};
        set_wts = {set_wts, w};
      end
      if (!last) return;
      total = 0;
      cost = 0;
      med = '0;
      found = 0;
      foreach (set_wts[j]) total += set_wts[j];
      target = total / 2 + (total & 1);
      foreach (set_vals[j]) begin
        if (!(found && set_vals[j] >= med)) begin
          acc = 0;
          foreach (set_vals[k]) if (set_vals[k] <= set_vals[j]) acc += set_wts[k];
          if (acc >= target) begin
            med = set_vals[j];
            found = 1;
          end
        end
      end
      foreach (set_vals[j]) begin
        d = (set_vals[j] >= med) ? set_vals[j] - med : med - set_vals[j];
        cost += d * set_wts[j];
      end
      exp_median = {exp_median, med};
      exp_cost = {exp_cost, cost[wmdc_pkg::COST_W-1:0]};
      set_vals.delete();
      set_wts.delete();
    endfunction

    function void check_result(logic [VB-1:0] m, logic [wmdc_pkg::COST_W-1:0] c);
      if (exp_median.size() == 0) begin
        $display("%0t: unexpected result median=%0d cost=%0d", $time, m, c);
        errors++;
        return;
      end
      if (m !== exp_median[0]) begin
        $display("%0t: median expected %0d actual %0d", $time, exp_median[0], m);
        errors++;
      end
      if (c !== exp_cost[0]) begin
        $display("%0t: cost expected %0d actual %0d", $time, exp_cost[0], c);
        errors++;
      end
      void'(exp_median.pop_front());
      void'(exp_cost.pop_front());
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #1 clk = ~clk;

  wmdc_in_if in_ch();
  wmdc_out_if out_ch();

  weighted_median_deviation_cost dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  median_cost_board board = new();
  int tx_idle = 28;
  int rx_idle = 84;
  longint cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.item_value = '0;
    in_ch.item_weight = '0;
    in_ch.is_last = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_pair(in_ch.item_value, in_ch.item_weight, in_ch.is_last);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.median_value, out_ch.total_cost);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pair(int v, int w, bit last);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.item_value <= VB'(v);
    in_ch.item_weight <= WB'(w);
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    @(negedge clk);
    while (board.exp_median.size() != 0) @(negedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(VMAX);
      1: return $urandom_range(15);
      2: return VMAX - $urandom_range(15);
      default: return $urandom_range(1000, 1100);
    endcase
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(4))
      0: return 0;
      1: return WMAX;
      2: return $urandom_range(1, 8);
      default: return $urandom_range(WMAX);
    endcase
  endfunction

  task automatic send_random_set();
    int n;
    n = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 32);
    if ($urandom_range(99) < 5) wait_drained();
    for (int i = 0; i < n; i++) send_pair(pick_value(), pick_weight(), i == n - 1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // single pair sets at the field extremes
    send_pair(0, 0, 1);
    send_pair(VMAX, WMAX, 1);
    send_pair(VMAX, 0, 1);
    // zero total weight: smallest value wins
    send_pair(300, 0, 0);
    send_pair(7, 0, 0);
    send_pair(VMAX, 0, 1);
    // ties and an exact half split
    send_pair(50, 3, 0);
    send_pair(10, 2, 0);
    send_pair(50, 1, 0);
    send_pair(10, 2, 1);
    // extreme spread with heavy weights
    send_pair(0, WMAX, 0);
    send_pair(VMAX, WMAX, 0);
    send_pair(VMAX, WMAX, 0);
    send_pair(0, 1, 1);
    // odd total with zero weight entries mixed in
    send_pair(9, 0, 0);
    send_pair(4, 1, 0);
    send_pair(2, 0, 0);
    send_pair(6, 2, 1);
    wait_drained();

    for (int s = 0; s < 68; s++) begin
      if (s == 22) begin
        tx_idle = 84;
        rx_idle = 28;
      end
      if (s == 44) begin
        // full set: the pairs past capacity are dropped, last one still closes it
        tx_idle = 0;
        rx_idle = 0;
        for (int i = 0; i < CAP + 2; i++)
          send_pair(pick_value(), pick_weight(), i == CAP + 1);
      end
      send_random_set();
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (board.errors == 0 && board.exp_median.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
